### src/clock_calendar_setter_display_defines.svh
// assertion helpers for the clock calendar block
`ifndef CLOCK_CALENDAR_SETTER_DISPLAY_DEFINES_SVH
`define CLOCK_CALENDAR_SETTER_DISPLAY_DEFINES_SVH

// consequent checked in the same cycle
`define CCSD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ccsd assertion failed");

// consequent checked in the cycle after the antecedent
`define CCSD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ccsd assertion failed");

`endif

### src/ccsd_pkg.sv
`timescale 1ns / 1ps

package ccsd_pkg;

	typedef struct packed {
		logic [1:0] cmd;
		logic [2:0] field_sel;
		logic [6:0] new_year;
		logic [3:0] new_month;
		logic [4:0] new_day;
		logic [4:0] new_hour;
		logic [5:0] new_minute;
		logic [5:0] new_second;
	} ccsd_in_t;

	typedef struct packed {
		logic [23:0] digits;
		logic [5:0]  dot_mask;
		logic [5:0]  blink_mask;
		logic        write_back;
		logic [6:0]  out_year;
		logic [3:0]  out_month;
		logic [4:0]  out_day;
		logic [4:0]  out_hour;
		logic [5:0]  out_minute;
		logic [5:0]  out_second;
	} ccsd_out_t;

	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} ccsd_clock_t;

	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_COUNT   = 2'd1;
	localparam logic [1:0] CMD_REFRESH = 2'd2;
	localparam logic [1:0] CMD_TAKE_WB = 2'd3;

	localparam logic [2:0] FIELD_YEAR   = 3'd0;
	localparam logic [2:0] FIELD_MONTH  = 3'd1;
	localparam logic [2:0] FIELD_DAY    = 3'd2;
	localparam logic [2:0] FIELD_HOUR   = 3'd3;
	localparam logic [2:0] FIELD_MINUTE = 3'd4;
	localparam logic [2:0] FIELD_SECOND = 3'd5;

	localparam logic [2:0] MODE_DATE       = 3'd0;
	localparam logic [2:0] MODE_TIME       = 3'd1;
	localparam logic [2:0] MODE_SET_YEAR   = 3'd2;
	localparam logic [2:0] MODE_SET_DAY    = 3'd4;
	localparam logic [2:0] MODE_SET_HOUR   = 3'd5;
	localparam logic [2:0] MODE_RESET      = MODE_TIME;

	localparam logic [6:0] YEAR_MAX   = 7'd99;
	localparam logic [3:0] MONTH_MAX  = 4'd12;
	localparam logic [4:0] HOUR_MAX   = 5'd23;
	localparam logic [5:0] MINUTE_MAX = 6'd59;
	localparam logic [5:0] SECOND_MAX = 6'd59;
	localparam logic [5:0] SECOND_LATE = 6'd57;
	localparam logic [3:0] BLANK_DIGIT = 4'hF;
	localparam logic [5:0] TIME_DOTS   = 6'h0A;

	// leap when the year offset is a multiple of four within 2000..2099
	function automatic logic [4:0] month_length(input logic [6:0] yr, input logic [3:0] mon);
		logic [4:0] len;
		len = 5'd31;
		if (mon == 4'd4 || mon == 4'd6 || mon == 4'd9 || mon == 4'd11) begin
			len = 5'd30;
		end else if (mon == 4'd2) begin
			len = (yr[1:0] == 2'b00) ? 5'd29 : 5'd28;
		end
		return len;
	endfunction

	// divide by ten through a reciprocal, exact for every 7-bit input value
	function automatic logic [3:0] tens_of(input logic [6:0] v);
		logic [14:0] prod;
		prod = {8'd0, v} * 15'd205;
		return prod[14:11];
	endfunction

	function automatic logic [7:0] pair_of(input logic [6:0] v);
		logic [3:0] tens;
		logic [6:0] ones;
		tens = tens_of(v);
		ones = v - 7'({3'd0, tens} * 7'd10);
		return {tens, ones[3:0]};
	endfunction

endpackage

### src/ccsd_step.sv
`timescale 1ns / 1ps

module ccsd_step (
	input  ccsd_pkg::ccsd_in_t    item,
	input  ccsd_pkg::ccsd_clock_t cur,
	input  logic                  pending,
	output ccsd_pkg::ccsd_clock_t nxt,
	output logic                  nxt_pending,
	output logic                  write_back
);

	logic [4:0] cur_len;
	logic [3:0] sec_tens;

	assign cur_len  = ccsd_pkg::month_length(cur.year, cur.month);
	assign sec_tens = ccsd_pkg::tens_of({1'b0, cur.second});

	always_comb begin
		nxt         = cur;
		nxt_pending = pending;
		write_back  = 1'b0;
		unique case (item.cmd)
			ccsd_pkg::CMD_LOAD: begin
				nxt.year   = (item.new_year > ccsd_pkg::YEAR_MAX) ? 7'd0 : item.new_year;
				nxt.month  = (item.new_month == 4'd0 || item.new_month > ccsd_pkg::MONTH_MAX)
					? 4'd1 : item.new_month;
				nxt.day    = (item.new_day == 5'd0) ? 5'd1 : item.new_day;
				nxt.hour   = (item.new_hour > ccsd_pkg::HOUR_MAX) ? 5'd0 : item.new_hour;
				nxt.minute = (item.new_minute > ccsd_pkg::MINUTE_MAX) ? 6'd0 : item.new_minute;
				nxt.second = (item.new_second > ccsd_pkg::SECOND_MAX) ? 6'd0 : item.new_second;
			end
			ccsd_pkg::CMD_COUNT: begin
				nxt_pending = 1'b1;
				unique case (item.field_sel)
					ccsd_pkg::FIELD_YEAR: begin
						nxt.year = (cur.year >= ccsd_pkg::YEAR_MAX) ? 7'd0 : cur.year + 7'd1;
					end
					ccsd_pkg::FIELD_MONTH: begin
						nxt.month = (cur.month >= ccsd_pkg::MONTH_MAX) ? 4'd1 : cur.month + 4'd1;
					end
					ccsd_pkg::FIELD_DAY: begin
						nxt.day = (cur.day >= cur_len) ? 5'd1 : cur.day + 5'd1;
					end
					ccsd_pkg::FIELD_HOUR: begin
						nxt.hour = (cur.hour >= ccsd_pkg::HOUR_MAX) ? 5'd0 : cur.hour + 5'd1;
					end
					ccsd_pkg::FIELD_MINUTE: begin
						nxt.minute = (cur.minute >= ccsd_pkg::MINUTE_MAX)
							? 6'd0 : cur.minute + 6'd1;
					end
					ccsd_pkg::FIELD_SECOND: begin
						// next multiple of ten, wrapping at the minute
						nxt.second = (sec_tens >= 4'd5)
							? 6'd0 : 6'(({2'd0, sec_tens} + 6'd1) * 6'd10);
					end
					default: begin
						nxt_pending = pending;
					end
				endcase
			end
			ccsd_pkg::CMD_REFRESH: begin
				nxt_pending = pending;
			end
			ccsd_pkg::CMD_TAKE_WB: begin
				write_back  = pending;
				nxt_pending = 1'b0;
			end
			default: begin
				nxt_pending = pending;
			end
		endcase
	end

endmodule

### src/ccsd_display.sv
`timescale 1ns / 1ps

module ccsd_display (
	input  logic [2:0]            mode,
	input  ccsd_pkg::ccsd_clock_t clk_val,
	output logic [23:0]           digits,
	output logic [5:0]            dot_mask,
	output logic [5:0]            blink_mask
);

	logic [7:0] yr_pair, mon_pair, day_pair, hr_pair, min_pair, sec_pair;
	logic       date_view;
	logic [3:0] shift;

	assign yr_pair  = ccsd_pkg::pair_of(clk_val.year);
	assign mon_pair = ccsd_pkg::pair_of({3'd0, clk_val.month});
	assign day_pair = ccsd_pkg::pair_of({2'd0, clk_val.day});
	assign hr_pair  = ccsd_pkg::pair_of({2'd0, clk_val.hour});
	assign min_pair = ccsd_pkg::pair_of({1'b0, clk_val.minute});
	assign sec_pair = ccsd_pkg::pair_of({1'b0, clk_val.second});

	assign date_view = (mode == ccsd_pkg::MODE_DATE) ||
		(mode >= ccsd_pkg::MODE_SET_YEAR && mode <= ccsd_pkg::MODE_SET_DAY);

	always_comb begin
		digits     = {hr_pair, min_pair, sec_pair};
		dot_mask   = 6'd0;
		blink_mask = 6'd0;
		shift      = 4'd0;
		if (date_view) begin
			digits = {yr_pair, mon_pair, day_pair};
			if (mode != ccsd_pkg::MODE_DATE) begin
				shift      = {mode - ccsd_pkg::MODE_SET_YEAR, 1'b0};
				blink_mask = 6'b000011 << shift;
			end
		end else begin
			if (clk_val.hour < 5'd10) begin
				digits[23:20] = ccsd_pkg::BLANK_DIGIT;
			end
			dot_mask = ccsd_pkg::TIME_DOTS;
			if (mode >= ccsd_pkg::MODE_SET_HOUR) begin
				shift      = {mode - ccsd_pkg::MODE_SET_HOUR, 1'b0};
				blink_mask = 6'b000011 << shift;
			end else begin
				// cascade of blinking digits on round values; seconds also blink from SECOND_LATE
				if (sec_pair[3:0] == 4'd0) begin
					blink_mask[5:4] = 2'b11;
					if (clk_val.second == 6'd0) begin
						blink_mask[3] = 1'b1;
						if (min_pair[3:0] == 4'd0) begin
							blink_mask[2] = 1'b1;
							if (clk_val.minute == 6'd0) begin
								blink_mask[1] = 1'b1;
								if (hr_pair[3:0] == 4'd0) begin
									blink_mask[0] = 1'b1;
								end
							end
						end
					end
				end
				if (clk_val.second >= ccsd_pkg::SECOND_LATE) begin
					blink_mask[5:4] = 2'b11;
				end
			end
		end
	end

endmodule

### src/clock_calendar_setter_display.sv
`timescale 1ns / 1ps
// channel   | signals                      | width
// ----------+------------------------------+-------------------------
// input     | in_valid in_ready in_data    | ccsd_in_t, 38 bits
// output    | out_valid out_ready out_data | ccsd_out_t, 70 bits
// config    | cfg_we cfg_wdata             | display mode, 3 bits
//
// one request per cycle if in_ready is high; result the cycle after it is taken
// the clock state and the result register are both written at that same edge
// in_ready drops only while a result waits and out_ready is low
// arst_n clears the clock to 2000-01-01 00:00:00, mode to time view
`include "clock_calendar_setter_display_defines.svh"

module clock_calendar_setter_display (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ccsd_pkg::ccsd_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ccsd_pkg::ccsd_out_t out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_wdata
);

	ccsd_pkg::ccsd_clock_t clock_q, clock_nxt;
	ccsd_pkg::ccsd_out_t   out_data_q;
	logic                  pending_q, pending_nxt;
	logic                  wb_nxt;
	logic                  out_valid_q;
	logic [2:0]            mode_q;
	logic                  in_accept;
	logic [23:0]           digits_nxt;
	logic [5:0]            dots_nxt, blink_nxt;
	logic                  take_wb_acc, count_acc, month_follows, clock_ok;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	ccsd_step u_step (
		.item        (in_data),
		.cur         (clock_q),
		.pending     (pending_q),
		.nxt         (clock_nxt),
		.nxt_pending (pending_nxt),
		.write_back  (wb_nxt)
	);

	ccsd_display u_display (
		.mode       (mode_q),
		.clk_val    (clock_nxt),
		.digits     (digits_nxt),
		.dot_mask   (dots_nxt),
		.blink_mask (blink_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q.year   <= 7'd0;
			clock_q.month  <= 4'd1;
			clock_q.day    <= 5'd1;
			clock_q.hour   <= 5'd0;
			clock_q.minute <= 6'd0;
			clock_q.second <= 6'd0;
			pending_q      <= 1'b0;
			out_valid_q    <= 1'b0;
			mode_q         <= ccsd_pkg::MODE_RESET;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (in_accept) begin
				clock_q     <= clock_nxt;
				pending_q   <= pending_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset
	always_ff @(posedge clk) begin
		if (in_accept) begin
			out_data_q.digits     <= digits_nxt;
			out_data_q.dot_mask   <= dots_nxt;
			out_data_q.blink_mask <= blink_nxt;
			out_data_q.write_back <= wb_nxt;
			out_data_q.out_year   <= clock_nxt.year;
			out_data_q.out_month  <= clock_nxt.month;
			out_data_q.out_day    <= clock_nxt.day;
			out_data_q.out_hour   <= clock_nxt.hour;
			out_data_q.out_minute <= clock_nxt.minute;
			out_data_q.out_second <= clock_nxt.second;
		end
	end

	assign take_wb_acc   = in_accept && (in_data.cmd == ccsd_pkg::CMD_TAKE_WB);
	assign count_acc     = in_accept && (in_data.cmd == ccsd_pkg::CMD_COUNT) &&
		(in_data.field_sel <= ccsd_pkg::FIELD_SECOND);
	assign month_follows = out_valid_q && (out_data_q.out_month == clock_q.month);
	assign clock_ok      = (clock_q.month >= 4'd1) && (clock_q.month <= ccsd_pkg::MONTH_MAX) &&
		(clock_q.hour <= ccsd_pkg::HOUR_MAX) && (clock_q.day != 5'd0);

	`CCSD_ASSERT_NEXT(a_take_wb_clears, take_wb_acc, !pending_q)
	`CCSD_ASSERT_NEXT(a_count_sets, count_acc, pending_q)
	`CCSD_ASSERT_NEXT(a_result_follows, in_accept, month_follows)
	`CCSD_ASSERT_NOW(a_clock_range, 1'b1, clock_ok)

endmodule
